>>> hdl/mp2s_pkg.sv
// Shared types, constants and helpers for the stride-2 max pooling block.
// No dependencies; imported by every module under hdl/.
package mp2s_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int MAX_GRID_WIDTH = 1024;
  localparam int STORE_DEPTH    = MAX_GRID_WIDTH / 2;
  localparam int ADDR_W         = $clog2(STORE_DEPTH);
  localparam int POS_W          = 11;
  localparam int CFG_DATA_W     = 10;
  localparam int CFG_INDEX_W    = 3;
  // power of two, pointers wrap on their own
  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t MIN_VALUE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] CFG_KERNEL_THREE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PAD_LEFT     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_PAD_RIGHT    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_PAD_TOP      = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_PAD_BOTTOM   = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_TAIL_MODE    = 3'd7;

  // line store operations
  typedef logic [1:0] op_t;
  localparam op_t OP_WR_ROW    = 2'd0; // write row partial max
  localparam op_t OP_WR_SHARED = 2'd1; // write shared row max (3x3)
  localparam op_t OP_EMIT2     = 2'd2; // read row store, emit 2x2 result
  localparam op_t OP_EMIT3     = 2'd3; // read both stores, emit 3x3, write shared

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    sample_t           hmax;
    logic              row_end;
    logic              plane_end;
  } cmd_t;

  function automatic sample_t smax(input sample_t a, input sample_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

>>> hdl/max_pool_2d_stride2.sv
// Stride-2 max pooling, 2x2 or 3x3 window, over one padded feature-map plane.
// Top level: mp2s_front -> mp2s_fifo -> mp2s_back. Uses mp2s_pkg.
//
//  channel | dir | handshake           | payload
//  s_*     | in  | s_tvalid/s_tready   | s_tdata[15:0] sample
//  m_*     | out | m_tvalid/m_tready   | m_tdata[15:0] pooled, m_tlast row_end,
//          |     |                     | m_tuser[0] plane_end
//  cfg_*   | in  | cfg_we              | cfg_index register, cfg_data value
//
// One sample per clock while the command queue has room; the result of a
// window passes the queue, a store read and the output register, in order.
// Line stores are single-port-per-side RAMs of 512 entries, no clearing pass.
// Reset clears positions, config to defaults and all valid flags.
// The command queue absorbs output stalls; input stalls only once it fills.
module max_pool_2d_stride2 import mp2s_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [15:0]            s_tdata,   // [15:0] sample
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [15:0]            m_tdata,   // [15:0] pooled
  output logic                   m_tlast,
  output logic [0:0]             m_tuser    // [0] plane_end
);

  cmd_t    cmd, head;
  logic    cmd_push, cmd_full, cmd_pop, cmd_not_empty;
  sample_t pooled;
  logic    row_end, plane_end;

  mp2s_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sample   (sample_t'(s_tdata)),
    .cmd      (cmd),
    .cmd_push (cmd_push),
    .cmd_full (cmd_full)
  );

  mp2s_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (cmd),
    .full     (cmd_full),
    .pop      (cmd_pop),
    .head     (head),
    .not_empty(cmd_not_empty)
  );

  mp2s_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .not_empty(cmd_not_empty),
    .pop      (cmd_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .pooled   (pooled),
    .row_end  (row_end),
    .plane_end(plane_end)
  );

  assign m_tdata = pooled;
  assign m_tlast = row_end;
  assign m_tuser = plane_end;

endmodule

>>> hdl/mp2s_front.sv
// Front end: configuration registers, grid position tracking, border handling
// and horizontal window max. Issues line store commands. Uses mp2s_pkg.
module mp2s_front import mp2s_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  sample_t                sample,
  output cmd_t                   cmd,
  output logic                   cmd_push,
  input  logic                   cmd_full
);

  logic                  kernel_three;
  logic [CFG_DATA_W-1:0] image_width;
  logic [CFG_DATA_W-1:0] image_height;
  logic [1:0]            pad_left;
  logic [1:0]            pad_right;
  logic [1:0]            pad_top;
  logic [1:0]            pad_bottom;
  logic                  tail_mode;

  logic [POS_W-1:0] col;
  logic [POS_W-1:0] row;
  sample_t          win0;
  sample_t          win1;

  logic [POS_W-1:0]  base_w, base_h, grid_w, grid_h;
  logic [POS_W-1:0]  x_end, y_end;
  logic [POS_W-1:0]  col_inc, row_inc;
  logic              acc, border, col_last, row_last;
  sample_t           v;
  logic [ADDR_W-1:0] half;

  assign s_tready = !cmd_full;
  assign acc      = s_tvalid && s_tready;

  // padded grid size; tail pad makes (grid - window) even
  always_comb begin
    base_w = POS_W'(pad_left) + POS_W'(image_width) + POS_W'(pad_right);
    base_h = POS_W'(pad_top) + POS_W'(image_height) + POS_W'(pad_bottom);
    grid_w = base_w + POS_W'(!tail_mode && (base_w[0] ^ kernel_three));
    grid_h = base_h + POS_W'(!tail_mode && (base_h[0] ^ kernel_three));
    x_end  = POS_W'(pad_left) + POS_W'(image_width);
    y_end  = POS_W'(pad_top) + POS_W'(image_height);
  end

  assign col_inc  = col + POS_W'(1);
  assign row_inc  = row + POS_W'(1);
  assign col_last = col_inc >= grid_w;
  assign row_last = row_inc >= grid_h;

  assign border = (col < POS_W'(pad_left)) || (col >= x_end) ||
                  (row < POS_W'(pad_top))  || (row >= y_end);
  assign v      = border ? MIN_VALUE : sample;
  assign half   = col[ADDR_W:1];

  always_comb begin
    cmd           = '0;
    cmd_push      = 1'b0;
    // last window of a row/plane when the next one would not fit
    cmd.row_end   = (col + POS_W'(2)) >= grid_w;
    cmd.plane_end = cmd.row_end && ((row + POS_W'(2)) >= grid_h);
    if (!kernel_three) begin
      if (col[0]) begin
        cmd.hmax = smax(win0, v);
        cmd.addr = half;
        cmd.op   = row[0] ? OP_EMIT2 : OP_WR_ROW;
        cmd_push = acc;
      end
    end else begin
      if ((|col[POS_W-1:1]) && !col[0]) begin
        cmd.hmax = smax(smax(win1, win0), v);
        cmd.addr = half - ADDR_W'(1);
        priority if (row[0]) begin
          cmd.op = OP_WR_ROW;
        end else if (|row[POS_W-1:1]) begin
          cmd.op = OP_EMIT3;
        end else begin
          cmd.op = OP_WR_SHARED;
        end
        cmd_push = acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_three <= 1'b0;
      image_width  <= CFG_DATA_W'(1);
      image_height <= CFG_DATA_W'(1);
      pad_left     <= '0;
      pad_right    <= '0;
      pad_top      <= '0;
      pad_bottom   <= '0;
      tail_mode    <= 1'b0;
      col          <= '0;
      row          <= '0;
      win0         <= '0;
      win1         <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KERNEL_THREE: kernel_three <= cfg_data[0];
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        CFG_PAD_LEFT:     pad_left     <= cfg_data[1:0];
        CFG_PAD_RIGHT:    pad_right    <= cfg_data[1:0];
        CFG_PAD_TOP:      pad_top      <= cfg_data[1:0];
        CFG_PAD_BOTTOM:   pad_bottom   <= cfg_data[1:0];
        CFG_TAIL_MODE:    tail_mode    <= cfg_data[0];
      endcase
      // any write restarts the plane
      col <= '0;
      row <= '0;
    end else if (acc) begin
      win1 <= win0;
      win0 <= v;
      if (col_last) begin
        col <= '0;
        row <= row_last ? '0 : row_inc;
      end else begin
        col <= col_inc;
      end
    end
  end

`ifndef SYNTHESIS
  a_col_wrap: assert property (@(posedge clk) disable iff (rst)
    (acc && col_last && !cfg_we) |=> (col == '0))
    else $error("column did not wrap at end of grid row");
`endif

endmodule

>>> hdl/mp2s_fifo.sv
// Short command queue between front and back end.
// Register-based, FIFO_DEPTH entries of cmd_t. Uses mp2s_pkg.
module mp2s_fifo import mp2s_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic not_empty
);

  cmd_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;

  assign full      = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + FIFO_CNT_W'(1);
        2'b01:   count <= count - FIFO_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty command queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full command queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("command queue count out of range");
`endif

endmodule

>>> hdl/mp2s_back.sv
// Back end: the two line stores of partial maxima, the vertical max and the
// output register. Consumes commands from mp2s_fifo. Uses mp2s_pkg.
module mp2s_back import mp2s_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cmd_t    head,
  input  logic    not_empty,
  output logic    pop,
  output logic    m_tvalid,
  input  logic    m_tready,
  output sample_t pooled,
  output logic    row_end,
  output logic    plane_end
);

  sample_t row_mem    [STORE_DEPTH];
  sample_t shared_mem [STORE_DEPTH];
  sample_t row_q;
  sample_t shared_q;

  logic    s1_valid;
  logic    s1_three;
  sample_t s1_hmax;
  logic    s1_row_end;
  logic    s1_plane_end;

  logic    out_free, adv, emit;
  logic    row_we, row_re, shared_we, shared_re;
  sample_t result;

  assign out_free = !m_tvalid || m_tready;
  assign adv      = !s1_valid || out_free;
  assign pop      = not_empty && adv;

  assign emit      = (head.op == OP_EMIT2) || (head.op == OP_EMIT3);
  assign row_we    = pop && (head.op == OP_WR_ROW);
  assign row_re    = pop && emit;
  assign shared_we = pop && ((head.op == OP_WR_SHARED) || (head.op == OP_EMIT3));
  assign shared_re = pop && (head.op == OP_EMIT3);

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[head.addr] <= head.hmax;
    end
    if (row_re) begin
      row_q <= row_mem[head.addr];
    end
  end

  // read and write hit the same entry on a 3x3 emit: old value is read
  always_ff @(posedge clk) begin
    if (shared_we) begin
      shared_mem[head.addr] <= head.hmax;
    end
    if (shared_re) begin
      shared_q <= shared_mem[head.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_three     <= (head.op == OP_EMIT3);
      s1_hmax      <= head.hmax;
      s1_row_end   <= head.row_end;
      s1_plane_end <= head.plane_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= pop && emit;
    end
  end

  always_comb begin
    result = smax(row_q, s1_hmax);
    if (s1_three) begin
      result = smax(result, shared_q);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      pooled    <= result;
      row_end   <= s1_row_end;
      plane_end <= s1_plane_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s1_valid;
    end
  end

`ifndef SYNTHESIS
  a_s1_source: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> ($past(pop) || $past(s1_valid)))
    else $error("read stage valid without a popped command");
`endif

endmodule
